@@ hdl/wfs_pkg.sv @@
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types and constants of the weight fill sequencer: phase codes,
// configuration register indexes, configuration and control state structs.
// ----------------------------------------------------------------------------
package wfs_pkg;

  // default weight width (grams)
  localparam int WEIGHT_BITS_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // counter width for the confirm counters
  localparam int CNT_W = 8;

  // register reset values
  localparam logic [15:0]      MIN_WEIGHT_RST    = 16'd100;
  localparam logic [15:0]      TARGET_RST        = 16'd0;
  localparam logic [9:0]       STOP_MARGIN_RST   = 10'd2;
  localparam logic [CNT_W-1:0] PRESENT_TICKS_RST = 8'd5;
  localparam logic [CNT_W-1:0] DONE_TICKS_RST    = 8'd3;

  // sequencer phases
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_ARM  = 2'd1,
    PH_FILL = 2'd2,
    PH_STOP = 2'd3
  } wfs_phase_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MIN_WEIGHT    = 3'd0,
    CFG_TARGET        = 3'd1,
    CFG_STOP_MARGIN   = 3'd2,
    CFG_PRESENT_TICKS = 3'd3,
    CFG_DONE_TICKS    = 3'd4
  } wfs_cfg_idx_t;

  // configuration registers
  typedef struct packed {
    logic [15:0]      min_weight;
    logic [15:0]      target;
    logic [9:0]       stop_margin;
    logic [CNT_W-1:0] present_ticks;
    logic [CNT_W-1:0] done_ticks;
  } wfs_cfg_t;

  // control state of the sequencer
  typedef struct packed {
    wfs_phase_t       phase;
    logic             auto_mode;
    logic [CNT_W-1:0] present_cnt;
    logic [CNT_W-1:0] done_cnt;
    logic             spike;
  } wfs_ctrl_t;

endpackage

@@ hdl/wfs_tick.sv @@
// ----------------------------------------------------------------------------
// wfs_tick
// Next-state logic of one control tick: container detection, arming, fill
// completion, record tracking with spike detection and the final report.
// ----------------------------------------------------------------------------
module wfs_tick #(
  parameter int WEIGHT_BITS = wfs_pkg::WEIGHT_BITS_DEF
) (
  input  wfs_pkg::wfs_cfg_t        cfg,
  input  wfs_pkg::wfs_ctrl_t       ctrl_q,
  input  logic [WEIGHT_BITS-1:0]   setpoint_q,
  input  logic [WEIGHT_BITS-1:0]   container_q,
  input  logic [WEIGHT_BITS-1:0]   record_q,
  input  logic [WEIGHT_BITS-1:0]   pre_spike_q,
  input  logic [WEIGHT_BITS-1:0]   raw_weight,
  input  logic [WEIGHT_BITS-1:0]   net_weight,
  input  logic                     start_request,
  input  logic                     stop_request,
  output wfs_pkg::wfs_ctrl_t       ctrl_d,
  output logic [WEIGHT_BITS-1:0]   setpoint_d,
  output logic [WEIGHT_BITS-1:0]   container_d,
  output logic [WEIGHT_BITS-1:0]   record_d,
  output logic [WEIGHT_BITS-1:0]   pre_spike_d,
  output logic                     report_valid,
  output logic [WEIGHT_BITS-1:0]   final_amount
);

  localparam int SUM_W  = WEIGHT_BITS + 11;
  localparam int RISE_W = WEIGHT_BITS + 5;
  localparam logic [wfs_pkg::CNT_W-1:0] CNT_MAX = '1;

  logic [WEIGHT_BITS-1:0] min_w;
  logic [WEIGHT_BITS-1:0] target_w;
  logic                   absent;
  logic                   reached;
  logic [WEIGHT_BITS-1:0] rise;
  logic [RISE_W-1:0]      rise_x20;
  logic                   is_spike;

  // registers taken modulo the weight width
  assign min_w    = WEIGHT_BITS'(cfg.min_weight);
  assign target_w = WEIGHT_BITS'(cfg.target);
  assign absent   = raw_weight < min_w;

  // remaining amount below margin: setpoint - net < margin, done without sign
  assign reached = SUM_W'(setpoint_q) < (SUM_W'(net_weight) + SUM_W'(cfg.stop_margin));

  // rise > record/20 is the same as 20*rise > record
  assign rise     = net_weight - record_q;
  assign rise_x20 = (RISE_W'(rise) << 4) + (RISE_W'(rise) << 2);
  assign is_spike = rise_x20 > RISE_W'(record_q);

  // one tick of the sequencer
  always_comb begin
    ctrl_d       = ctrl_q;
    setpoint_d   = setpoint_q;
    container_d  = container_q;
    record_d     = record_q;
    pre_spike_d  = pre_spike_q;
    report_valid = 1'b0;
    final_amount = '0;

    // stop wins over start
    if (stop_request) begin
      ctrl_d.auto_mode = 1'b0;
      ctrl_d.phase     = wfs_pkg::PH_STOP;
      ctrl_d.done_cnt  = '0;
    end else if (start_request) begin
      ctrl_d.auto_mode = 1'b1;
    end

    case (ctrl_d.phase)
      wfs_pkg::PH_WAIT: begin
        if (absent) begin
          ctrl_d.present_cnt = '0;
        end else if (ctrl_d.present_cnt != CNT_MAX) begin
          ctrl_d.present_cnt = ctrl_d.present_cnt + 1'b1;
        end
        if (ctrl_d.present_cnt > cfg.present_ticks) begin
          container_d        = raw_weight;
          ctrl_d.present_cnt = '0;
          ctrl_d.phase       = wfs_pkg::PH_ARM;
        end
      end
      wfs_pkg::PH_ARM: begin
        if (absent) begin
          ctrl_d.phase = wfs_pkg::PH_STOP;
        end else begin
          setpoint_d   = (target_w != '0) ? target_w : WEIGHT_BITS'(1);
          ctrl_d.phase = wfs_pkg::PH_FILL;
        end
      end
      wfs_pkg::PH_FILL: begin
        // container pulled away mid-fill acts as a stop
        if (absent) begin
          ctrl_d.auto_mode = 1'b0;
          ctrl_d.phase     = wfs_pkg::PH_STOP;
          ctrl_d.done_cnt  = '0;
        end else if (reached) begin
          if (ctrl_d.done_cnt != CNT_MAX) begin
            ctrl_d.done_cnt = ctrl_d.done_cnt + 1'b1;
          end
          if (ctrl_d.done_cnt >= cfg.done_ticks) begin
            ctrl_d.phase    = wfs_pkg::PH_STOP;
            ctrl_d.done_cnt = '0;
            ctrl_d.spike    = 1'b0;
            pre_spike_d     = '0;
            record_d        = net_weight;
          end
        end else begin
          ctrl_d.done_cnt = '0;
        end
      end
      wfs_pkg::PH_STOP: begin
        // record tracking while a fill is pending
        if ((setpoint_q != '0) && (net_weight > record_q)) begin
          if (is_spike) begin
            if (!ctrl_q.spike) begin
              ctrl_d.spike = 1'b1;
              pre_spike_d  = record_q;
            end
          end else begin
            record_d = net_weight;
          end
        end
        // container removed: report a pending fill and rearm if in auto mode
        if (absent) begin
          if (setpoint_q != '0) begin
            report_valid = 1'b1;
            final_amount = ctrl_d.spike ? pre_spike_d : record_d;
            setpoint_d   = '0;
          end
          if (ctrl_d.auto_mode) begin
            ctrl_d.phase       = wfs_pkg::PH_WAIT;
            ctrl_d.present_cnt = '0;
          end
        end
      end
      default: begin
        ctrl_d.phase = wfs_pkg::PH_STOP;
      end
    endcase
  end

endmodule

@@ hdl/weight_fill_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// weight_fill_sequencer_core
// Fill sequencer for a weighing station: detects a container, arms and runs
// the fill to the target, then watches the settled weight and reports it.
// ----------------------------------------------------------------------------
//  channel | dir | word contents (lowest bits first)
//  --------+-----+----------------------------------------------------------
//  in_     | in  | raw_weight, net_weight, start_request, stop_request
//  out_    | out | phase, drive_enable, fill_setpoint, container_weight,
//          |     | report_valid, final_amount
//  cfg_    | in  | register index, write data
//
//  each input word yields one output word through the input register,
//  the tick logic and the output register; one word per cycle
//  is sustained as long as out_tready stays high
//  a stalled output register holds the word and blocks the tick logic;
//  the input register still takes a word while it is empty
//  rst_n is synchronous, active low; cfg_ready is always high
// ----------------------------------------------------------------------------
module weight_fill_sequencer_core #(
  parameter int WEIGHT_BITS = wfs_pkg::WEIGHT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  // raw_weight, net_weight, start_request, stop_request, zero pad
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((2*WEIGHT_BITS+2+7)/8)*8-1:0]     in_tdata,

  // phase, drive_enable, fill_setpoint, container_weight, report_valid,
  // final_amount, zero pad
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((3*WEIGHT_BITS+4+7)/8)*8-1:0]     out_tdata,

  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [wfs_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [wfs_pkg::CFG_DATA_W-1:0]           cfg_data
);

  localparam int WB     = WEIGHT_BITS;
  localparam int IN_W   = ((2*WB+2+7)/8)*8;
  localparam int OUT_U  = 3*WB+4;
  localparam int OUT_W  = ((OUT_U+7)/8)*8;

  // configuration and state registers
  wfs_pkg::wfs_cfg_t  cfg_r;
  wfs_pkg::wfs_ctrl_t ctrl_r, ctrl_nxt;
  logic [WB-1:0]      setpoint_r, setpoint_nxt;
  logic [WB-1:0]      container_r, container_nxt;
  logic [WB-1:0]      record_r, record_nxt;
  logic [WB-1:0]      pre_spike_r, pre_spike_nxt;

  // input register
  logic               in_valid_r;
  logic [IN_W-1:0]    in_data_r;

  // output register
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic               advance;
  logic               rep_valid;
  logic [WB-1:0]      final_amount;
  logic [OUT_U-1:0]   out_word;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_weight    <= wfs_pkg::MIN_WEIGHT_RST;
      cfg_r.target        <= wfs_pkg::TARGET_RST;
      cfg_r.stop_margin   <= wfs_pkg::STOP_MARGIN_RST;
      cfg_r.present_ticks <= wfs_pkg::PRESENT_TICKS_RST;
      cfg_r.done_ticks    <= wfs_pkg::DONE_TICKS_RST;
    end else if (cfg_valid) begin
      case (wfs_pkg::wfs_cfg_idx_t'(cfg_index))
        wfs_pkg::CFG_MIN_WEIGHT:    cfg_r.min_weight    <= cfg_data;
        wfs_pkg::CFG_TARGET:        cfg_r.target        <= cfg_data;
        wfs_pkg::CFG_STOP_MARGIN:   cfg_r.stop_margin   <= cfg_data[9:0];
        wfs_pkg::CFG_PRESENT_TICKS: cfg_r.present_ticks <= cfg_data[wfs_pkg::CNT_W-1:0];
        wfs_pkg::CFG_DONE_TICKS:    cfg_r.done_ticks    <= cfg_data[wfs_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  // tick logic
  wfs_tick #(
    .WEIGHT_BITS (WB)
  ) u_tick (
    .cfg           (cfg_r),
    .ctrl_q        (ctrl_r),
    .setpoint_q    (setpoint_r),
    .container_q   (container_r),
    .record_q      (record_r),
    .pre_spike_q   (pre_spike_r),
    .raw_weight    (in_data_r[WB-1:0]),
    .net_weight    (in_data_r[2*WB-1:WB]),
    .start_request (in_data_r[2*WB]),
    .stop_request  (in_data_r[2*WB+1]),
    .ctrl_d        (ctrl_nxt),
    .setpoint_d    (setpoint_nxt),
    .container_d   (container_nxt),
    .record_d      (record_nxt),
    .pre_spike_d   (pre_spike_nxt),
    .report_valid  (rep_valid),
    .final_amount  (final_amount)
  );

  // sequencer state commits when the tick result moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.phase       <= wfs_pkg::PH_STOP;
      ctrl_r.auto_mode   <= 1'b0;
      ctrl_r.present_cnt <= '0;
      ctrl_r.done_cnt    <= '0;
      ctrl_r.spike       <= 1'b0;
      setpoint_r         <= '0;
      container_r        <= '0;
      record_r           <= '0;
      pre_spike_r        <= '0;
    end else if (advance) begin
      ctrl_r      <= ctrl_nxt;
      setpoint_r  <= setpoint_nxt;
      container_r <= container_nxt;
      record_r    <= record_nxt;
      pre_spike_r <= pre_spike_nxt;
    end
  end

  // result word
  assign out_word = {final_amount, rep_valid, container_nxt, setpoint_nxt,
                     (ctrl_nxt.phase == wfs_pkg::PH_FILL), ctrl_nxt.phase};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= OUT_W'(out_word);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a report only leaves the stopped phase or starts a new wait
  a_report_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[2*WB+3]) |->
      (out_data_r[1:0] == wfs_pkg::PH_STOP || out_data_r[1:0] == wfs_pkg::PH_WAIT))
    else $error("report issued outside stopped/wait phase");

  // a report clears the pending setpoint
  a_report_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && rep_valid) |=> (setpoint_r == '0))
    else $error("setpoint not cleared after report");

  // state only moves with a tick
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(ctrl_r) && $stable(setpoint_r) && $stable(record_r)))
    else $error("sequencer state changed without a tick");

  // an empty output register never blocks the input side
  a_no_false_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

endmodule
